>>> hdl/fpaf_pkg.sv
package fpaf_pkg;

  // field widths
  localparam int RAW_W    = 32;
  localparam int CHAR_W   = 7;
  localparam int NUM_CHAR = 6;
  localparam int TDATA_W  = 48;

  // double-dabble lanes: lane a carries the 4-digit value, lane b the 2-digit fraction
  localparam int BIN_W     = 14;
  localparam int NUM_CELLS = BIN_W;
  localparam int DIG_A     = 4;
  localparam int DIG_B     = 2;
  localparam int BCD_A_W   = 4 * DIG_A;
  localparam int BCD_B_W   = 4 * DIG_B;

  // range limits
  localparam logic [RAW_W-1:0] DEC_LIMIT  = 32'd10000;
  localparam logic [RAW_W-1:0] BIN_LIMIT  = 32'd256000;
  localparam logic [14:0]      FRAC_SCALE = 15'd100;

  // ascii codes
  localparam logic [CHAR_W-1:0] CH_SPACE = 7'h20;
  localparam logic [CHAR_W-1:0] CH_STAR  = 7'h2A;
  localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2D;
  localparam logic [CHAR_W-1:0] CH_DOT   = 7'h2E;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;

  typedef enum logic {
    MODE_DEC = 1'b0,
    MODE_BIN = 1'b1
  } format_mode_t;

  typedef struct packed {
    format_mode_t       mode;
    logic               neg;
    logic               ovf;
    logic [BIN_W-1:0]   bin_a;
    logic [BCD_A_W-1:0] bcd_a;
    logic [BIN_W-1:0]   bin_b;
    logic [BCD_B_W-1:0] bcd_b;
  } cell_word_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d);
    return CH_ZERO + {3'b000, d};
  endfunction

endpackage

>>> hdl/fpaf_prep.sv
module fpaf_prep
  import fpaf_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [RAW_W-1:0] raw_value,
  input  format_mode_t     mode,
  output logic             out_valid,
  input  logic             out_ready,
  output cell_word_t       out_word
);

  logic             valid;
  cell_word_t       word;
  cell_word_t       word_next;
  logic             neg;
  logic [RAW_W-1:0] mag;
  logic [14:0]      frac_prod;

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_word  = word;

  always_comb begin
    neg       = raw_value[RAW_W-1];
    mag       = neg ? (32'd0 - raw_value) : raw_value;
    frac_prod = {7'd0, raw_value[7:0]} * FRAC_SCALE;

    word_next       = '0;
    word_next.mode  = mode;
    word_next.neg   = neg;
    if (mode == MODE_DEC) begin
      word_next.ovf   = (mag >= DEC_LIMIT);
      word_next.bin_a = mag[BIN_W-1:0];
    end else begin
      word_next.ovf   = (raw_value >= BIN_LIMIT);
      word_next.bin_a = {4'd0, raw_value[17:8]};
      // floor(100 * frac / 256), with leading zeros above it
      word_next.bin_b = {7'd0, frac_prod[14:8]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      word <= word_next;
    end
  end

endmodule

>>> hdl/fpaf_cell.sv
module fpaf_cell
  import fpaf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  cell_word_t in_word,
  output logic       out_valid,
  input  logic       out_ready,
  output cell_word_t out_word
);

  logic               valid;
  cell_word_t         word;
  cell_word_t         word_next;
  logic [BCD_A_W-1:0] adj_a;
  logic [BCD_B_W-1:0] adj_b;

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_word  = word;

  // one double-dabble step on each lane: add 3 to digits of 5 and up, then shift
  always_comb begin
    adj_a = in_word.bcd_a;
    adj_b = in_word.bcd_b;
    for (int i = 0; i < DIG_A; i++) begin
      if (in_word.bcd_a[4*i +: 4] >= 4'd5) begin
        adj_a[4*i +: 4] = in_word.bcd_a[4*i +: 4] + 4'd3;
      end
    end
    for (int i = 0; i < DIG_B; i++) begin
      if (in_word.bcd_b[4*i +: 4] >= 4'd5) begin
        adj_b[4*i +: 4] = in_word.bcd_b[4*i +: 4] + 4'd3;
      end
    end
    word_next       = in_word;
    word_next.bcd_a = {adj_a[BCD_A_W-2:0], in_word.bin_a[BIN_W-1]};
    word_next.bin_a = {in_word.bin_a[BIN_W-2:0], 1'b0};
    word_next.bcd_b = {adj_b[BCD_B_W-2:0], in_word.bin_b[BIN_W-1]};
    word_next.bin_b = {in_word.bin_b[BIN_W-2:0], 1'b0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      word <= word_next;
    end
  end

endmodule

>>> hdl/fpaf_fmt.sv
module fpaf_fmt
  import fpaf_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  cell_word_t         in_word,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [TDATA_W-1:0] m_tdata,
  output logic               m_tuser
);

  logic              valid;
  logic [CHAR_W-1:0] chars [NUM_CHAR];
  logic [CHAR_W-1:0] chars_next [NUM_CHAR];
  logic              ovf;
  logic [3:0]        da [DIG_A];
  logic [3:0]        db [DIG_B];

  assign in_ready = !valid || m_tready;
  assign m_tvalid = valid;
  assign m_tuser  = ovf;
  assign m_tdata  = {6'd0, chars[5], chars[4], chars[3], chars[2], chars[1], chars[0]};

  always_comb begin
    for (int i = 0; i < DIG_A; i++) begin
      da[i] = in_word.bcd_a[4*i +: 4];
    end
    for (int i = 0; i < DIG_B; i++) begin
      db[i] = in_word.bcd_b[4*i +: 4];
    end
    if (in_word.mode == MODE_DEC) begin
      if (in_word.ovf) begin
        chars_next[0] = CH_SPACE;
        chars_next[1] = CH_STAR;
        chars_next[2] = CH_DOT;
        chars_next[3] = CH_STAR;
        chars_next[4] = CH_STAR;
        chars_next[5] = CH_STAR;
      end else begin
        chars_next[0] = in_word.neg ? CH_MINUS : CH_SPACE;
        chars_next[1] = digit_char(da[3]);
        chars_next[2] = CH_DOT;
        chars_next[3] = digit_char(da[2]);
        chars_next[4] = digit_char(da[1]);
        chars_next[5] = digit_char(da[0]);
      end
    end else begin
      if (in_word.ovf) begin
        chars_next[0] = CH_STAR;
        chars_next[1] = CH_STAR;
        chars_next[2] = CH_STAR;
        chars_next[3] = CH_DOT;
        chars_next[4] = CH_STAR;
        chars_next[5] = CH_STAR;
      end else begin
        // leading zeros of the integer part become spaces
        chars_next[0] = (da[2] != 4'd0) ? digit_char(da[2]) : CH_SPACE;
        chars_next[1] = (da[2] != 4'd0 || da[1] != 4'd0) ? digit_char(da[1]) : CH_SPACE;
        chars_next[2] = digit_char(da[0]);
        chars_next[3] = CH_DOT;
        chars_next[4] = digit_char(db[1]);
        chars_next[5] = digit_char(db[0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      chars <= chars_next;
      ovf   <= in_word.ovf;
    end
  end

endmodule

>>> hdl/fixed_point_ascii_formatter_core.sv
// fixed-point to ascii formatter: each 32-bit word on the slave side becomes one word of six
// ascii characters plus an overflow flag on the master side. format_mode 0 reads the value as
// signed thousandths and prints "sd.ddd" (sign is space or minus), any value outside
// -9999..9999 prints " *.***"; format_mode 1 reads it as unsigned with 8 fraction bits and
// prints "iii.ff" with the integer part space-padded and the fraction floor(100*frac/256),
// any value of 256000 or more prints "***.**". one word is taken per cycle unless the master
// side stalls; a word passes one range-check stage, a row of 14 double-dabble cells (one
// binary bit shifted into the bcd digits per cell) and the output register. every stage
// has its own valid bit, so a stall on the master side fills the bubbles before the slave
// side is held. format_mode is sampled as a word enters; change it only while idle.
module fixed_point_ascii_formatter_core
  import fpaf_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  // configuration: bit 0 is format_mode
  input  logic               cfg_wr_en,
  input  logic               cfg_wr_data,
  // slave side, tdata: raw_value[31:0]
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [RAW_W-1:0]   s_tdata,
  // master side, tdata: char_zero[6:0], char_one[13:7], char_two[20:14],
  // char_three[27:21], char_four[34:28], char_five[41:35], zero fill [47:42]
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [TDATA_W-1:0] m_tdata,
  // tuser: overflow[0]
  output logic               m_tuser
);

  format_mode_t format_mode;

  // stage handshakes: index 0 is the range-check stage, 1..NUM_CELLS are the cells
  logic       stage_valid [NUM_CELLS+1];
  logic       stage_ready [NUM_CELLS+1];
  cell_word_t stage_word  [NUM_CELLS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      format_mode <= MODE_DEC;
    end else if (cfg_wr_en) begin
      format_mode <= format_mode_t'(cfg_wr_data);
    end
  end

  // sign, magnitude, range check and the split into integer and fraction lanes
  fpaf_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .raw_value (s_tdata),
    .mode      (format_mode),
    .out_valid (stage_valid[0]),
    .out_ready (stage_ready[0]),
    .out_word  (stage_word[0])
  );

  // binary to bcd, one bit per cell
  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    fpaf_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (stage_valid[i]),
      .in_ready  (stage_ready[i]),
      .in_word   (stage_word[i]),
      .out_valid (stage_valid[i+1]),
      .out_ready (stage_ready[i+1]),
      .out_word  (stage_word[i+1])
    );
  end

  // digits to characters, held in the output register
  fpaf_fmt u_fmt (
    .clk      (clk),
    .rst      (rst),
    .in_valid (stage_valid[NUM_CELLS]),
    .in_ready (stage_ready[NUM_CELLS]),
    .in_word  (stage_word[NUM_CELLS]),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

>>> hdl/fpaf_checker.sv
module fpaf_checker
  import fpaf_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               m_tvalid,
  input logic               m_tready,
  input logic [TDATA_W-1:0] m_tdata,
  input logic               m_tuser
);

  // nothing leaves right after reset
  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("word out right after reset");

  // every word carries its point in the third or fourth place
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[20:14] == CH_DOT || m_tdata[27:21] == CH_DOT))
    else $error("point missing");

  // overflow always shows a star in the last place
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata[41:35] == CH_STAR))
    else $error("overflow without stars");

  // a stalled word stays
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> m_tvalid)
    else $error("stalled word dropped");

endmodule

bind fixed_point_ascii_formatter_core fpaf_checker u_fpaf_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

>>> sim/fpaf_result_checker.sv
module fpaf_result_checker
  import fpaf_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic               cfg_wr_data,
  input  logic               s_tvalid,
  input  logic               s_tready,
  input  logic [RAW_W-1:0]   s_tdata,
  input  logic               m_tvalid,
  input  logic               m_tready,
  input  logic [TDATA_W-1:0] m_tdata,
  input  logic               m_tuser,
  output int                 fail_count,
  output int                 words_pending
);

  typedef struct packed {
    logic [NUM_CHAR-1:0][CHAR_W-1:0] ch;
    logic                            overflow;
  } text_word_t;

  format_mode_t shown_mode;
  text_word_t   expected_text_q[$];

  function automatic logic [CHAR_W-1:0] ascii_digit(input int unsigned d);
    return CH_ZERO + CHAR_W'(d % 10);
  endfunction

  function automatic text_word_t render_value(input format_mode_t mode,
                                              input logic [RAW_W-1:0] raw);
    text_word_t       t;
    logic             neg;
    logic [RAW_W-1:0] mag;
    int unsigned      whole;
    int unsigned      frac;
    t.overflow = 1'b0;
    if (mode == MODE_DEC) begin
      neg = raw[RAW_W-1];
      mag = neg ? -raw : raw;
      if (mag >= DEC_LIMIT) begin
        t.ch = {CH_STAR, CH_STAR, CH_STAR, CH_DOT, CH_STAR, CH_SPACE};
        t.overflow = 1'b1;
      end else begin
        t.ch[0] = neg ? CH_MINUS : CH_SPACE;
        t.ch[1] = ascii_digit(mag / 1000);
        t.ch[2] = CH_DOT;
        t.ch[3] = ascii_digit(mag / 100);
        t.ch[4] = ascii_digit(mag / 10);
        t.ch[5] = ascii_digit(mag);
      end
    end else begin
      if (raw >= BIN_LIMIT) begin
        t.ch = {CH_STAR, CH_STAR, CH_DOT, CH_STAR, CH_STAR, CH_STAR};
        t.overflow = 1'b1;
      end else begin
        whole = raw >> 8;
        frac  = (100 * int'(raw[7:0])) >> 8;
        t.ch[0] = (whole >= 100) ? ascii_digit(whole / 100) : CH_SPACE;
        t.ch[1] = (whole >= 10) ? ascii_digit(whole / 10) : CH_SPACE;
        t.ch[2] = ascii_digit(whole);
        t.ch[3] = CH_DOT;
        t.ch[4] = ascii_digit(frac / 10);
        t.ch[5] = ascii_digit(frac);
      end
    end
    return t;
  endfunction

  // left to right as a printable string
  function automatic logic [8*NUM_CHAR-1:0] as_text(input text_word_t t);
    logic [8*NUM_CHAR-1:0] s;
    for (int k = 0; k < NUM_CHAR; k++) begin
      s[8*(NUM_CHAR-1-k) +: 8] = {1'b0, t.ch[k]};
    end
    return s;
  endfunction

  always @(posedge clk) begin : watch_words
    text_word_t got;
    text_word_t want;
    logic       bad;
    if (rst) begin
      shown_mode <= MODE_DEC;
      expected_text_q.delete();
      words_pending <= 0;
    end else begin
      if (cfg_wr_en) begin
        shown_mode <= format_mode_t'(cfg_wr_data);
      end
      if (s_tvalid && s_tready) begin
        expected_text_q.push_back(render_value(shown_mode, s_tdata));
      end
      if (m_tvalid && m_tready) begin
        for (int k = 0; k < NUM_CHAR; k++) begin
          got.ch[k] = m_tdata[CHAR_W*k +: CHAR_W];
        end
        got.overflow = m_tuser;
        if (expected_text_q.size() == 0) begin
          if (fail_count < 10) begin
            $display("unexpected word \"%s\" overflow %0b", as_text(got), got.overflow);
          end
          fail_count <= fail_count + 1;
        end else begin
          want = expected_text_q.pop_front();
          bad = 1'b0;
          for (int k = 0; k < NUM_CHAR; k++) begin
            if (got.ch[k] !== want.ch[k]) begin
              bad = 1'b1;
            end
          end
          if (got.overflow !== want.overflow) begin
            bad = 1'b1;
          end
          if (bad) begin
            if (fail_count < 10) begin
              $display("mismatch: expected \"%s\" overflow %0b, got \"%s\" overflow %0b",
                       as_text(want), want.overflow, as_text(got), got.overflow);
            end
            fail_count <= fail_count + 1;
          end
        end
      end
      words_pending <= expected_text_q.size();
    end
  end

endmodule

>>> sim/tb_fixed_point_ascii_formatter_core.sv
// drives values into the formatter in both format modes, with random gaps on the
// slave side and random stalls on the master side; the checker beside the block
// predicts every word and compares
module tb_fixed_point_ascii_formatter_core
  import fpaf_pkg::*;
();

  // no accepted word for this long means the block hung
  localparam int STALL_LIMIT = 2000;
  // pipeline is 16 deep, leave some margin
  localparam int DRAIN_CYCLES = 24;
  localparam int RANDOM_WORDS_PER_PHASE = 270;
  // bit n is the mode of random phase n: dec, bin, bin, dec, bin, dec
  localparam logic [5:0] PHASE_MODES = 6'b010110;

  logic               clk = 1'b0;
  logic               rst;
  logic               cfg_wr_en;
  logic               cfg_wr_data;
  logic               s_tvalid;
  logic               s_tready;
  logic [RAW_W-1:0]   s_tdata;
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [TDATA_W-1:0] m_tdata;
  logic               m_tuser;

  int fail_count;
  int words_pending;
  int ready_hold = 0;
  int ready_pick;
  int quiet_cycles = 0;
  bit no_gaps = 1'b0;

  always #10 clk = ~clk;

  fixed_point_ascii_formatter_core dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser)
  );

  fpaf_result_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tuser       (m_tuser),
    .fail_count    (fail_count),
    .words_pending (words_pending)
  );

  // master side: ready or stalled for random stretches, mostly short stalls,
  // a few long ones, and now and then a long run with no stall at all
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      ready_hold <= 0;
    end else if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else begin
      ready_pick = $urandom_range(0, 99);
      if (ready_pick < 50) begin
        m_tready <= 1'b1;
        ready_hold <= $urandom_range(0, 15);
      end else if (ready_pick < 58) begin
        m_tready <= 1'b1;
        ready_hold <= $urandom_range(100, 300);
      end else if (ready_pick < 92) begin
        m_tready <= 1'b0;
        ready_hold <= $urandom_range(0, 3);
      end else begin
        m_tready <= 1'b0;
        ready_hold <= $urandom_range(15, 60);
      end
    end
  end

  // watchdog: cycles with no word moving on either side
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one word on the slave side, after a random gap
  task automatic send_word(input logic [RAW_W-1:0] raw);
    int pick;
    int gap;
    // flip between gappy and back-to-back stretches now and then
    if ($urandom_range(0, 49) == 0) begin
      no_gaps = ~no_gaps;
    end
    pick = $urandom_range(0, 99);
    if (no_gaps || pick < 55) begin
      gap = 0;
    end else if (pick < 90) begin
      gap = $urandom_range(1, 3);
    end else begin
      gap = $urandom_range(8, 40);
    end
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= raw;
    do @(posedge clk); while (!s_tready);
  endtask

  // stop sending and let every expected word come out
  task automatic drain_block();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_mode(input format_mode_t mode);
    drain_block();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= mode;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [RAW_W-1:0] random_raw(input format_mode_t mode);
    int unsigned      pick;
    logic [RAW_W-1:0] mag;
    pick = $urandom_range(0, 99);
    if (mode == MODE_DEC) begin
      if (pick < 60) begin
        mag = $urandom_range(0, 9999);
      end else if (pick < 75) begin
        // around the range edge
        mag = $urandom_range(9990, 10010);
      end else if (pick < 85) begin
        mag = $urandom_range(0, 99);
      end else begin
        return $urandom;
      end
      return $urandom_range(0, 1) ? -mag : mag;
    end
    if (pick < 55) begin
      return $urandom_range(0, 255999);
    end else if (pick < 65) begin
      return $urandom_range(255900, 256100);
    end else if (pick < 80) begin
      // integer part where the space padding changes
      mag = (pick % 2) ? $urandom_range(98, 101) : $urandom_range(8, 11);
      return (mag << 8) | $urandom_range(0, 255);
    end else if (pick < 88) begin
      return $urandom_range(0, 1023);
    end
    return $urandom;
  endfunction

  initial begin : stimulus
    format_mode_t mode;
    rst         = 1'b1;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = 1'b0;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // decimal: zero, smallest steps, both range edges, extremes of the bits
    set_mode(MODE_DEC);
    send_word(32'd0);
    send_word(32'd1);
    send_word(-32'sd1);
    send_word(32'd9999);
    send_word(-32'sd9999);
    send_word(32'd10000);
    send_word(-32'sd10000);
    send_word(32'h7FFF_FFFF);
    send_word(32'h8000_0000);
    send_word(32'd1234);
    send_word(-32'sd567);
    send_word(32'd10);

    // binary: padding edges, fraction rounding, range edge, all ones
    set_mode(MODE_BIN);
    send_word(32'd0);
    send_word(32'd3);
    send_word(32'd128);
    send_word(32'd255);
    send_word(32'd256);
    send_word(32'd2559);
    send_word(32'd2560);
    send_word(32'd25599);
    send_word(32'd25600);
    send_word(32'd255999);
    send_word(32'd256000);
    send_word(32'hFFFF_FFFF);

    for (int ph = 0; ph < 6; ph++) begin
      mode = format_mode_t'(PHASE_MODES[ph]);
      set_mode(mode);
      for (int n = 0; n < RANDOM_WORDS_PER_PHASE; n++) begin
        send_word(random_raw(mode));
      end
    end

    drain_block();
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
